### src/udw_pkg.sv
// Shared types and constants for the UTF-8 display width block.
// No dependencies; every other file of the block imports this package.
package udw_pkg;

    // Width of the running cell sum; the result word is always 16 bits.
    localparam int SUM_BITS   = 16;
    localparam int TOTAL_BITS = 16;
    localparam int EXT_BITS   = (SUM_BITS > TOTAL_BITS) ? SUM_BITS : TOTAL_BITS;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    localparam int TAB_BITS   = 4;
    localparam logic [TAB_BITS-1:0] TAB_RESET = 4'd4;

    // Cells contributed by one decoded symbol plus flushed lone bytes.
    localparam int CELL_BITS  = 5;

    localparam int CODE_BITS  = 21;

    // Depth of the token queue between decoder and accumulator.
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // Lead byte ranges and the second-byte limits of strict UTF-8.
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_A0   = 8'hA0;

    // One decoded step: an optional code point, the cells of lone bytes that
    // count as characters of their own, and the end-of-string mark.
    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 code_vld;
        logic [2:0]           lone;
        logic                 eos;
    } t_token;

endpackage

### src/udw_queue.sv
// Short token queue between the UTF-8 decoder and the width accumulator.
// Depends on udw_pkg for the token type and the queue depth.
module udw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  udw_pkg::t_token i_tok,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_vld,
    output udw_pkg::t_token o_tok
);
    import udw_pkg::*;

    t_token                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;

    function automatic logic [Q_PTR_BITS-1:0] ptr_inc(input logic [Q_PTR_BITS-1:0] p);
        if (p == Q_PTR_BITS'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_full = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_tok  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/udw_front.sv
// UTF-8 decoder front end: takes one byte per word and emits one token.
// Depends on udw_pkg for the token type and the lead byte constants.
module udw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output udw_pkg::t_token o_tok
);
    import udw_pkg::*;

    logic [7:0]           r_lead;
    logic [1:0]           r_pcnt;
    logic [2:0]           r_explen;
    logic [CODE_BITS-1:0] r_part;
    logic [1:0]           r_lone;

    logic [7:0]           n_lead;
    logic [1:0]           n_pcnt;
    logic [2:0]           n_explen;
    logic [CODE_BITS-1:0] n_part;
    logic [1:0]           n_lone;

    logic                 ok;
    logic                 lead_now;
    logic [CODE_BITS-1:0] pc;
    logic [2:0]           lone_acc;
    logic                 ends;

    always_comb begin
        n_lead   = r_lead;
        n_pcnt   = r_pcnt;
        n_explen = r_explen;
        n_part   = r_part;
        n_lone   = r_lone;
        ok       = 1'b0;
        lead_now = 1'b0;
        pc       = {r_part[CODE_BITS-7:0], i_byte[5:0]};
        lone_acc = '0;
        ends     = (i_byte == 8'd0) || i_last;
        o_tok    = '0;

        if (i_byte != 8'd0) begin
            if (r_pcnt == 2'd0) begin
                lead_now = 1'b1;
            end else begin
                ok = (i_byte[7:6] == 2'b10);
                if (r_pcnt == 2'd1) begin
                    if (r_lead == LEAD_E0 && i_byte < CONT_A0) ok = 1'b0;
                    if (r_lead == LEAD_ED && i_byte >= CONT_A0) ok = 1'b0;
                    if (r_lead == LEAD_F0 && i_byte < CONT_90) ok = 1'b0;
                    if (r_lead == LEAD_F4 && i_byte >= CONT_90) ok = 1'b0;
                end
                if (!ok) begin
                    // Broken sequence: its bytes count as lone bytes and
                    // this byte starts over as a lead.
                    lone_acc = {1'b0, r_lone};
                    n_pcnt   = 2'd0;
                    lead_now = 1'b1;
                end else if (({1'b0, r_pcnt} + 3'd1) >= r_explen) begin
                    o_tok.code     = pc;
                    o_tok.code_vld = 1'b1;
                    n_pcnt         = 2'd0;
                end else begin
                    n_part = pc;
                    n_pcnt = r_pcnt + 2'd1;
                    n_lone = r_lone + {1'b0, i_byte[5]};
                end
            end

            if (lead_now) begin
                if (!i_byte[7]) begin
                    o_tok.code     = CODE_BITS'(i_byte);
                    o_tok.code_vld = 1'b1;
                end else if (i_byte >= LEAD2_LO && i_byte <= LEAD2_HI) begin
                    n_explen = 3'd2;
                    n_part   = CODE_BITS'(i_byte[4:0]);
                    n_lead   = i_byte;
                    n_pcnt   = 2'd1;
                    n_lone   = 2'd1;
                end else if (i_byte >= LEAD3_LO && i_byte <= LEAD3_HI) begin
                    n_explen = 3'd3;
                    n_part   = CODE_BITS'(i_byte[3:0]);
                    n_lead   = i_byte;
                    n_pcnt   = 2'd1;
                    n_lone   = 2'd1;
                end else if (i_byte >= LEAD4_LO && i_byte <= LEAD4_HI) begin
                    n_explen = 3'd4;
                    n_part   = CODE_BITS'(i_byte[2:0]);
                    n_lead   = i_byte;
                    n_pcnt   = 2'd1;
                    n_lone   = 2'd1;
                end else begin
                    o_tok.code     = CODE_BITS'(i_byte);
                    o_tok.code_vld = 1'b1;
                end
            end
        end

        if (ends) begin
            if (n_pcnt != 2'd0) begin
                lone_acc = lone_acc + {1'b0, n_lone};
            end
            n_pcnt = 2'd0;
        end

        o_tok.lone = lone_acc;
        o_tok.eos  = ends;
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_lead   <= n_lead;
            r_explen <= n_explen;
            r_part   <= n_part;
            r_lone   <= n_lone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 2'd0;
        end else if (i_take) begin
            r_pcnt <= n_pcnt;
        end
    end

endmodule

### src/udw_back.sv
// Width accumulator back end: maps tokens to cells, sums, emits totals.
// Depends on udw_pkg for the token type, sum widths and tab reset value.
module udw_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [udw_pkg::TAB_BITS-1:0] i_cfg_wdata,
    input  logic                         i_vld,
    input  udw_pkg::t_token              i_tok,
    output logic                         o_pop,
    output logic                         o_vld,
    output logic [udw_pkg::TOTAL_BITS-1:0] o_total,
    input  logic                         i_ready
);
    import udw_pkg::*;

    localparam logic [SUM_BITS:0] SUM_MAX = {1'b0, {SUM_BITS{1'b1}}};

    logic [TAB_BITS-1:0]   r_tab;
    logic [SUM_BITS-1:0]   r_sum;
    logic                  r_out_vld;
    logic [TOTAL_BITS-1:0] r_total;

    logic [CELL_BITS-1:0]  cells;
    logic [CELL_BITS-1:0]  inc;
    logic [SUM_BITS:0]     raw_sum;
    logic [SUM_BITS-1:0]   n_sum;
    logic [EXT_BITS-1:0]   sum_ext;
    logic [TOTAL_BITS-1:0] n_total;

    function automatic logic in_rng(input logic [CODE_BITS-1:0] c,
                                    input logic [CODE_BITS-1:0] lo,
                                    input logic [CODE_BITS-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic [CELL_BITS-1:0] cells_of(input logic [CODE_BITS-1:0] c,
                                                      input logic [TAB_BITS-1:0] tab);
        logic mark;
        logic wide;
        mark = in_rng(c, 21'h00300, 21'h0036F) || in_rng(c, 21'h01AB0, 21'h01AFF) ||
               in_rng(c, 21'h01DC0, 21'h01DFF) || in_rng(c, 21'h020D0, 21'h020FF) ||
               in_rng(c, 21'h0FE20, 21'h0FE2F);
        wide = (c == 21'h02329) || (c == 21'h0232A) ||
               in_rng(c, 21'h01100, 21'h0115F) || (c == 21'h0303F) ||
               in_rng(c, 21'h02E80, 21'h0A4CF) || in_rng(c, 21'h0AC00, 21'h0D7A3) ||
               in_rng(c, 21'h0F900, 21'h0FAFF) || in_rng(c, 21'h0FE10, 21'h0FE19) ||
               in_rng(c, 21'h0FE30, 21'h0FE6F) || in_rng(c, 21'h0FF00, 21'h0FF60) ||
               in_rng(c, 21'h0FFE0, 21'h0FFE6) || in_rng(c, 21'h1F300, 21'h1FAFF) ||
               in_rng(c, 21'h20000, 21'h3FFFD);
        if (c == 21'h00009) begin
            return CELL_BITS'(tab);
        end
        if (c < 21'h00020 || in_rng(c, 21'h0007F, 21'h0009F) || mark) begin
            return '0;
        end
        if (wide) begin
            return CELL_BITS'(2);
        end
        return CELL_BITS'(1);
    endfunction

    assign o_pop   = i_vld && (!r_out_vld || i_ready);
    assign o_vld   = r_out_vld;
    assign o_total = r_total;

    always_comb begin
        cells   = i_tok.code_vld ? cells_of(i_tok.code, r_tab) : '0;
        inc     = cells + CELL_BITS'(i_tok.lone);
        raw_sum = {1'b0, r_sum} + (SUM_BITS+1)'(inc);
        n_sum   = (raw_sum > SUM_MAX) ? SUM_MAX[SUM_BITS-1:0] : raw_sum[SUM_BITS-1:0];
        sum_ext = EXT_BITS'(n_sum);
        n_total = (sum_ext > EXT_BITS'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_tok.eos) begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab     <= TAB_RESET;
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tab <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_sum <= i_tok.eos ? '0 : n_sum;
            end
            if (o_pop && i_tok.eos) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

### src/utf8_display_width.sv
// Top level of the UTF-8 display width block.
// Depends on udw_pkg, udw_front, udw_queue and udw_back.

// The block takes a UTF-8 string one byte per word on the slave stream and
// returns the string's terminal display width, in cells, as one word on the
// master stream when the string ends. A string ends at a byte with tlast set
// or at a zero byte; the zero byte itself adds nothing. Decoding is strict:
// overlong forms, surrogates and values above U+10FFFF are refused, and the
// bytes of a broken sequence are counted one by one as lone characters
// before the offending byte is decoded again as a new lead. A tab adds the
// configured tab width (reset value 4), control codes and combining marks
// add nothing, wide East Asian and emoji ranges add two, everything else
// one. The total saturates at 65535. The block accepts one byte every clock
// cycle for as long as the downstream side keeps up: the decoder turns each
// byte into a token in the cycle it is accepted, a two-entry token queue
// sits between it and the accumulator, and the accumulator retires one
// token per cycle into the running sum while its output register is free
// or being read. The total of a string passes from the token queue into
// the output register, from which it is valid on the master side. A stalled
// output register holds the total while the queue keeps absorbing bytes
// until it is full. The user must write the tab width through the
// configuration port while no string is in flight; the block does not
// enforce this.
module utf8_display_width (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration: tab width in cells.
    input  logic                         i_cfg_we,
    input  logic [udw_pkg::TAB_BITS-1:0] i_cfg_wdata,
    // Byte input stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] text_byte
    input  logic                         s_axis_tlast,   // last_byte
    // Width result stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [udw_pkg::TOTAL_BITS-1:0] m_axis_tdata  // [15:0] total_width
);
    import udw_pkg::*;

    t_token front_tok;
    t_token q_tok;
    logic   q_full;
    logic   q_vld;
    logic   push;
    logic   pop;

    // A byte is taken whenever the token queue has room.
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    udw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (push),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_tok   (front_tok)
    );

    udw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (front_tok),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_tok   (q_tok)
    );

    udw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vld       (q_vld),
        .i_tok       (q_tok),
        .o_pop       (pop),
        .o_vld       (m_axis_tvalid),
        .o_total     (m_axis_tdata),
        .i_ready     (m_axis_tready)
    );

    // Reset leaves no total pending on the output.
    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // An end-of-string token that was pushed is in the queue next cycle.
    a_eos_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && front_tok.eos) |=> q_vld)
        else $error("end-of-string token lost");

    // The queue never drains without the accumulator popping it.
    a_q_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_vld && !pop) |=> q_vld)
        else $error("queue emptied without a pop");

    // An end-of-string token is retired only while the output register can take a total.
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && q_tok.eos) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("total would overwrite a pending result");

endmodule

### tb/sv/udw_width_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 display width block: watches the byte and total streams,
// keeps its own decoder and cell count, and compares every total. Depends on udw_pkg.
module udw_width_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [udw_pkg::TAB_BITS-1:0]   i_cfg_wdata,
    input  logic                           i_byte_valid,
    input  logic                           i_byte_ready,
    input  logic [7:0]                     i_byte,
    input  logic                           i_byte_last,
    input  logic                           i_total_valid,
    input  logic                           i_total_ready,
    input  logic [udw_pkg::TOTAL_BITS-1:0] i_total,
    output int                             o_errors,
    output int                             o_waiting,
    output int                             o_checked
);
    import udw_pkg::*;

    localparam logic [CODE_BITS-1:0] TAB_CHAR = 21'h09;

    // Decoder and sum state as the block should hold it.
    logic [TAB_BITS-1:0]   tab_cells;
    logic [7:0]            seq_lead;
    logic [1:0]            seq_taken;
    logic [2:0]            seq_len;
    logic [CODE_BITS-1:0]  seq_code;
    logic [15:0]           seq_cont;
    logic [SUM_BITS-1:0]   run_width;

    logic [TOTAL_BITS-1:0] width_due[$];
    logic [TOTAL_BITS-1:0] due;
    int mismatches = 0;
    int totals_checked = 0;
    int due_count = 0;

    assign o_errors  = mismatches;
    assign o_waiting = due_count;
    assign o_checked = totals_checked;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    function automatic logic [TAB_BITS-1:0] cells_for(input logic [CODE_BITS-1:0] c);
        logic mark;
        logic wide;
        mark = (c >= 21'h0300 && c <= 21'h036F) || (c >= 21'h1AB0 && c <= 21'h1AFF) ||
               (c >= 21'h1DC0 && c <= 21'h1DFF) || (c >= 21'h20D0 && c <= 21'h20FF) ||
               (c >= 21'hFE20 && c <= 21'hFE2F);
        wide = c == 21'h2329 || c == 21'h232A || (c >= 21'h1100 && c <= 21'h115F) ||
               c == 21'h303F || (c >= 21'h2E80 && c <= 21'hA4CF) ||
               (c >= 21'hAC00 && c <= 21'hD7A3) || (c >= 21'hF900 && c <= 21'hFAFF) ||
               (c >= 21'hFE10 && c <= 21'hFE19) || (c >= 21'hFE30 && c <= 21'hFE6F) ||
               (c >= 21'hFF00 && c <= 21'hFF60) || (c >= 21'hFFE0 && c <= 21'hFFE6) ||
               (c >= 21'h1F300 && c <= 21'h1FAFF) || (c >= 21'h20000 && c <= 21'h3FFFD);
        if (c == TAB_CHAR) begin
            return tab_cells;
        end
        if (c < 21'h20 || (c >= 21'h7F && c < 21'hA0) || mark) begin
            return '0;
        end
        return wide ? TAB_BITS'(2) : TAB_BITS'(1);
    endfunction

    task automatic add_width(input logic [TAB_BITS-1:0] n);
        logic [SUM_BITS:0] s;
        s = run_width + n;
        run_width = s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endtask

    task automatic clear_seq();
        seq_lead  = '0;
        seq_taken = '0;
        seq_len   = '0;
        seq_code  = '0;
        seq_cont  = '0;
    endtask

    // A broken or unfinished sequence counts each held byte as a character of its own.
    task automatic flush_seq();
        if (seq_taken != 0) begin
            add_width(cells_for({13'b0, seq_lead}));
            for (int k = 0; k + 1 < seq_taken && k < 2; k++) begin
                add_width(cells_for({13'b0, seq_cont[8*k +: 8]}));
            end
        end
        clear_seq();
    endtask

    task automatic start_char(input logic [7:0] b);
        if (b < 8'h80) begin
            add_width(cells_for({13'b0, b}));
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            seq_len = 3'd2;
            seq_code = {16'b0, b[4:0]};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            seq_len = 3'd3;
            seq_code = {17'b0, b[3:0]};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            seq_len = 3'd4;
            seq_code = {18'b0, b[2:0]};
        end else begin
            add_width(cells_for({13'b0, b}));
        end
        if (seq_len != 0) begin
            seq_lead  = b;
            seq_taken = 2'd1;
            seq_cont  = '0;
        end
    endtask

    task automatic next_byte(input logic [7:0] b);
        logic ok;
        int slot;
        if (seq_taken == 0) begin
            start_char(b);
        end else begin
            ok = (b[7:6] == 2'b10);
            // The second byte narrows the range for overlong, surrogate and too-large forms.
            if (ok && seq_taken == 1) begin
                if (seq_lead == LEAD_E0 && b < CONT_A0) ok = 1'b0;
                if (seq_lead == LEAD_ED && b >= CONT_A0) ok = 1'b0;
                if (seq_lead == LEAD_F0 && b < CONT_90) ok = 1'b0;
                if (seq_lead == LEAD_F4 && b >= CONT_90) ok = 1'b0;
            end
            if (!ok) begin
                flush_seq();
                start_char(b);
            end else begin
                seq_code = {seq_code[CODE_BITS-7:0], b[5:0]};
                if (int'(seq_taken) + 1 >= int'(seq_len)) begin
                    add_width(cells_for(seq_code));
                    clear_seq();
                end else begin
                    slot = int'(seq_taken) - 1;
                    seq_cont[8*slot +: 8] = b;
                    seq_taken = seq_taken + 2'd1;
                end
            end
        end
    endtask

    task automatic predict_word(input logic [7:0] b, input logic last);
        if (b != 0) begin
            next_byte(b);
        end
        if (b == 0 || last) begin
            flush_seq();
            width_due.push_back((EXT_BITS'(run_width) > EXT_BITS'(TOTAL_MAX)) ?
                                TOTAL_MAX : TOTAL_BITS'(run_width));
            run_width = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tab_cells = TAB_RESET;
            clear_seq();
            run_width = '0;
            width_due.delete();
        end else begin
            if (i_total_valid && i_total_ready) begin
                if (width_due.size() == 0) begin
                    report_mismatch($sformatf("total_width %0d arrived with no string open",
                                              i_total));
                end else begin
                    due = width_due.pop_front();
                    if (i_total !== due) begin
                        report_mismatch($sformatf("total_width got %0d, expected %0d",
                                                  i_total, due));
                    end
                    totals_checked++;
                end
            end
            if (i_cfg_we) begin
                tab_cells = i_cfg_wdata;
            end
            if (i_byte_valid && i_byte_ready) begin
                predict_word(i_byte, i_byte_last);
            end
        end
        due_count = width_due.size();
    end

endmodule

### tb/sv/utf8_display_width_tb.sv
`timescale 1ns / 100ps
// Top of the testbench for utf8_display_width: clock, reset, byte stimulus, output
// stalls and the verdict. Depends on udw_pkg, the block and udw_width_checker.
module utf8_display_width_tb;
    import udw_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int BYTES_PER_PHASE = 200;
    // The block holds at most a queue of two tokens and an output register,
    // so a handful of cycles covers anything still in flight.
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_FIRST      = 400;
    localparam int HOLD_PERIOD     = 2500;
    localparam int HOLD_CYCLES     = 160;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [TAB_BITS-1:0]   i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] text_byte
    logic                  s_axis_tlast = 1'b0; // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TOTAL_BITS-1:0] m_axis_tdata;        // [15:0] total_width

    int errors;
    int waiting;
    int checked;
    int cycles = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int rx_count = 0;
    int hold_left = 0;
    int hold_at = HOLD_FIRST;
    int holds_done = 0;
    int tab_settings = 1;

    // Bytes of the string being sent next.
    logic [7:0] text[$];

    utf8_display_width dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_wdata,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tlast,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata
    );

    udw_width_checker width_check (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_wdata,
        .i_byte_valid  (s_axis_tvalid),
        .i_byte_ready  (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_byte_last   (s_axis_tlast),
        .i_total_valid (m_axis_tvalid),
        .i_total_ready (m_axis_tready),
        .i_total       (m_axis_tdata),
        .o_errors      (errors),
        .o_waiting     (waiting),
        .o_checked     (checked)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: a correct run ends far below this count.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d totals outstanding", cycles, waiting);
            $display("FAILURE");
            $finish;
        end
    end

    // Output side. The stall pattern takes turns among always ready, a coin toss, one
    // cycle in eight, or mostly ready. At the first hold point, and then once per hold
    // period, the receiver stops for a long stretch, counted here, starting while the
    // sender is offering bytes, so the output register and token queue fill and the
    // input stalls.
    always @(negedge i_clk) begin
        rx_count = rx_count + 1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_count >= hold_at && s_axis_tvalid) begin
            hold_left = HOLD_CYCLES;
            hold_at = hold_at + HOLD_PERIOD;
            holds_done = holds_done + 1;
            m_axis_tready <= 1'b0;
        end else begin
            case ((rx_count / 256) % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (rx_count % 8 == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Offers one word and returns at the falling edge after it was taken. The sender
    // works in bursts; when one runs out it may drop tvalid for a gap first. tvalid is
    // lowered only for a gap that is not empty, so it is not lowered and raised within
    // the same time step.
    task automatic send_word(input logic [7:0] b, input logic mark);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1:    gap = 0;
                8, 9:    gap = $urandom_range(5, 24);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= mark;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_string(input bit mark_last);
        for (int i = 0; i < text.size(); i++) begin
            send_word(text[i], mark_last && (i == text.size() - 1));
        end
    endtask

    // Lets every expected total arrive, then a few more cycles, so the block is idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tab(input logic [TAB_BITS-1:0] cells);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cells;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tab_settings++;
    endtask

    // Picks a code point, mostly at or next to the edges of the cell classes and of the
    // encoding lengths. Surrogates and values past U+10FFFF are pulled back into range.
    function automatic logic [20:0] pick_code();
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] c;
        case ($urandom_range(0, 15))
            0, 1, 2, 3: begin lo = 21'h0;     hi = 21'h7F;     end
            4:          begin lo = 21'h80;    hi = 21'h7FF;    end
            5:          begin lo = 21'h800;   hi = 21'hFFFF;   end
            6:          begin lo = 21'h10000; hi = 21'h10FFFF; end
            default: begin
                case ($urandom_range(0, 19))
                    0:       begin lo = 21'h0300;  hi = 21'h036F;  end
                    1:       begin lo = 21'h1AB0;  hi = 21'h1AFF;  end
                    2:       begin lo = 21'h1DC0;  hi = 21'h1DFF;  end
                    3:       begin lo = 21'h20D0;  hi = 21'h20FF;  end
                    4:       begin lo = 21'hFE20;  hi = 21'hFE2F;  end
                    5:       begin lo = 21'h2329;  hi = 21'h232A;  end
                    6:       begin lo = 21'h1100;  hi = 21'h115F;  end
                    7:       begin lo = 21'h303F;  hi = 21'h303F;  end
                    8:       begin lo = 21'h2E80;  hi = 21'hA4CF;  end
                    9:       begin lo = 21'hAC00;  hi = 21'hD7A3;  end
                    10:      begin lo = 21'hF900;  hi = 21'hFAFF;  end
                    11:      begin lo = 21'hFE10;  hi = 21'hFE19;  end
                    12:      begin lo = 21'hFE30;  hi = 21'hFE6F;  end
                    13:      begin lo = 21'hFF00;  hi = 21'hFF60;  end
                    14:      begin lo = 21'hFFE0;  hi = 21'hFFE6;  end
                    15:      begin lo = 21'h1F300; hi = 21'h1FAFF; end
                    16:      begin lo = 21'h20000; hi = 21'h3FFFD; end
                    17:      begin lo = 21'h0;     hi = 21'h1F;    end
                    18:      begin lo = 21'h7F;    hi = 21'h9F;    end
                    default: begin lo = 21'hE000;  hi = 21'hFFFF;  end
                endcase
            end
        endcase
        case ($urandom_range(0, 4))
            0:       c = lo - 21'd1;
            1:       c = lo;
            2:       c = hi;
            3:       c = hi + 21'd1;
            default: c = 21'($urandom_range(lo, hi));
        endcase
        if (c > 21'h10FFFF) c = 21'h10FFFF;
        if (c >= 21'hD800 && c <= 21'hDFFF) c = 21'hD7FF;
        return c;
    endfunction

    // Appends the shortest UTF-8 form of a code point.
    task automatic push_code(input logic [20:0] c);
        if (c < 21'h80) begin
            text.push_back(c[7:0]);
        end else if (c < 21'h800) begin
            text.push_back({3'b110, c[10:6]});
            text.push_back({2'b10, c[5:0]});
        end else if (c < 21'h10000) begin
            text.push_back({4'b1110, c[15:12]});
            text.push_back({2'b10, c[11:6]});
            text.push_back({2'b10, c[5:0]});
        end else begin
            text.push_back({5'b11110, c[20:18]});
            text.push_back({2'b10, c[17:12]});
            text.push_back({2'b10, c[11:6]});
            text.push_back({2'b10, c[5:0]});
        end
    endtask

    // Builds one string. Most characters are well formed; the rest are cut-short or
    // corrupted sequences, forbidden second bytes, invalid leads and plain noise.
    task automatic build_string(output bit mark_last);
        int nchars;
        int n0;
        int len;
        logic [20:0] c;
        text.delete();
        nchars = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        repeat (nchars) begin
            case ($urandom_range(0, 99)) inside
                [0:69]: push_code(pick_code());
                [70:84]: begin
                    c = 21'($urandom_range(21'h80, 21'h10FFFF));
                    if (c >= 21'hD800 && c <= 21'hDFFF) c = 21'hE000;
                    n0 = text.size();
                    push_code(c);
                    len = text.size() - n0;
                    if ($urandom_range(0, 1) == 0) begin
                        void'(text.pop_back());
                    end else begin
                        text[n0 + $urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
                    end
                end
                [85:92]: begin
                    case ($urandom_range(0, 6))
                        0: begin
                            text.push_back(LEAD_E0);
                            text.push_back(8'($urandom_range(8'h80, 8'h9F)));
                        end
                        1: begin
                            text.push_back(LEAD_ED);
                            text.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                        end
                        2: begin
                            text.push_back(LEAD_F0);
                            text.push_back(8'($urandom_range(8'h80, 8'h8F)));
                        end
                        3: begin
                            text.push_back(LEAD_F4);
                            text.push_back(8'($urandom_range(8'h90, 8'hBF)));
                        end
                        4: begin
                            text.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                            text.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        5: begin
                            text.push_back(8'($urandom_range(8'hF5, 8'hFF)));
                            text.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        default: text.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    endcase
                end
                default: text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        // Most strings end on tlast; some end on a zero byte, with or without tlast.
        case ($urandom_range(0, 9))
            0: begin
                text.push_back(8'h00);
                mark_last = 1'b0;
            end
            1: begin
                text.push_back(8'h00);
                mark_last = 1'b1;
            end
            default: mark_last = 1'b1;
        endcase
    endtask

    task automatic run_random_strings();
        int start;
        bit mark_last;
        start = bytes_sent;
        while (bytes_sent - start < BYTES_PER_PHASE) begin
            build_string(mark_last);
            send_string(mark_last);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed strings at the reset tab width. First a clean mix: letter, tab,
        // DEL, a combining mark, a wide ideograph and an emoji.
        text = '{8'h41, 8'h09, 8'h7F, 8'hCC, 8'h80, 8'hE4, 8'hB8, 8'h80,
                 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_string(1'b1);
        // Overlong, surrogate and too-large second bytes, invalid leads, then a
        // sequence left open when a zero byte ends the string.
        text = '{8'hE0, 8'h80, 8'hED, 8'hA0, 8'hF4, 8'h90, 8'hFF, 8'hC0, 8'hC3, 8'h00};
        send_string(1'b0);
        // A zero byte that also carries tlast ends exactly one, empty string.
        text = '{8'h00};
        send_string(1'b1);
        // A sequence cut short by tlast is flushed as lone bytes.
        text = '{8'hF4, 8'h8F, 8'hBF};
        send_string(1'b1);

        // Widest tab, then random strings.
        settle();
        write_tab(4'hF);
        run_random_strings();

        // Tabs that take no cells.
        settle();
        write_tab(4'h0);
        run_random_strings();

        settle();
        write_tab(4'($urandom_range(1, 14)));
        run_random_strings();

        settle();
        write_tab(TAB_RESET);
        run_random_strings();

        settle();
        $display("Sent %0d bytes and checked %0d string totals over %0d tab widths,",
                 bytes_sent, checked, tab_settings);
        $display("with %0d long output hold-offs that backed up the byte input.", holds_done);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
